### src/dex_catch_handler_list_scanner_top_defines.svh
// Assertion macros shared by the catch handler list scanner RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef DEX_CATCH_HANDLER_LIST_SCANNER_TOP_DEFINES_SVH
`define DEX_CATCH_HANDLER_LIST_SCANNER_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define DCHLS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked out of reset.
`define DCHLS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/dchls_pkg.sv
// Package for the catch handler list scanner: word types, queue token, phase codes.
// No dependencies.
`timescale 1ns / 1ps

package dchls_pkg;

   // Walk phases; the first five double as the reported value kind.
   localparam logic [2:0] PH_COUNT    = 3'd0;
   localparam logic [2:0] PH_SIZE     = 3'd1;
   localparam logic [2:0] PH_TYPE     = 3'd2;
   localparam logic [2:0] PH_ADDR     = 3'd3;
   localparam logic [2:0] PH_CATCHALL = 3'd4;
   localparam logic [2:0] PH_IDLE     = 3'd5;

   // Fifth LEB128 byte sits at this byte position.
   localparam logic [2:0] LAST_POS = 3'd4;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       start_req;
   } req_word_type;

   typedef struct packed {
      logic        value_done;
      logic [2:0]  value_kind;
      logic [31:0] value_bits;
      logic        list_end;
      logic [31:0] bytes_used;
   } rsp_word_type;

   // Classified byte as it sits in the queue.
   typedef struct packed {
      logic [7:0] raw;
      logic       more;
      logic       start;
   } tok_type;

   typedef struct packed {
      logic    valid;
      tok_type tok;
   } q_head_type;

endpackage

### src/dchls_front.sv
// Front end: accepts request words, tags continuation/start, two-entry queue.
// Depends on dchls_pkg.
`timescale 1ns / 1ps

module dchls_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  dchls_pkg::req_word_type  req_word,
   output dchls_pkg::q_head_type    head,
   input  logic                     pop
);
   import dchls_pkg::*;

   tok_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;
   tok_type    tok;

   assign req_stall = (cnt_ff == 2'd2);
   assign push      = req_valid && !req_stall;

   always_comb begin
      tok.raw   = req_word.data_byte;
      tok.more  = req_word.data_byte[7];
      tok.start = req_word.start_req;
   end

   assign head.valid = (cnt_ff != 2'd0);
   assign head.tok   = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

### src/dchls_back.sv
// Back end: LEB128 accumulation, list walk and the registered response slot.
// Depends on dchls_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "dex_catch_handler_list_scanner_top_defines.svh"

module dchls_back (
   input  logic                     clock,
   input  logic                     reset,
   input  dchls_pkg::q_head_type    head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output dchls_pkg::rsp_word_type  rsp_word
);
   import dchls_pkg::*;

   logic [2:0]   phase_ff, phase_in;
   logic [31:0]  acc_ff, acc_in;
   logic [2:0]   pos_ff, pos_in;
   logic [31:0]  hl_ff, hl_in;
   logic [31:0]  pl_ff, pl_in;
   logic         cap_ff, cap_in;
   logic [31:0]  cnt_ff, cnt_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   // walk state as seen by this byte (start clears it first)
   logic [2:0]   ph;
   logic [31:0]  acc;
   logic [2:0]   pos;
   logic [31:0]  hl;
   logic [31:0]  pl;
   logic         cap;
   logic [31:0]  cnt;
   logic [6:0]   pay;
   logic [31:0]  acc_new;
   logic [31:0]  value;
   logic         last;
   logic         done;
   logic         list_end;
   logic [31:0]  hl_dec;
   logic [31:0]  pl_dec;

   assign pop = head.valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      ph  = head.tok.start ? PH_COUNT : phase_ff;
      acc = head.tok.start ? 32'd0    : acc_ff;
      pos = head.tok.start ? 3'd0     : pos_ff;
      hl  = head.tok.start ? 32'd0    : hl_ff;
      pl  = head.tok.start ? 32'd0    : pl_ff;
      cap = head.tok.start ? 1'b0     : cap_ff;
      cnt = head.tok.start ? 32'd0    : cnt_ff;
      pay = head.tok.raw[6:0];

      unique case (pos)
         3'd0:    acc_new = acc | {25'd0, pay};
         3'd1:    acc_new = acc | {18'd0, pay, 7'd0};
         3'd2:    acc_new = acc | {11'd0, pay, 14'd0};
         3'd3:    acc_new = acc | {4'd0, pay, 21'd0};
         default: acc_new = acc | {head.tok.raw[3:0], 28'd0};
      endcase

      last = (pos == LAST_POS) || !head.tok.more;

      value = acc_new;
      if (ph == PH_SIZE) begin
         unique case (pos)
            3'd0:    value = {{25{acc_new[6]}}, acc_new[6:0]};
            3'd1:    value = {{18{acc_new[13]}}, acc_new[13:0]};
            3'd2:    value = {{11{acc_new[20]}}, acc_new[20:0]};
            3'd3:    value = {{4{acc_new[27]}}, acc_new[27:0]};
            default: value = acc_new;
         endcase
      end

      hl_dec = hl - 32'd1;
      pl_dec = pl - 32'd1;

      phase_in = ph;
      acc_in   = acc;
      pos_in   = pos;
      hl_in    = hl;
      pl_in    = pl;
      cap_in   = cap;
      cnt_in   = cnt;
      done     = 1'b0;
      list_end = 1'b0;

      if (ph != PH_IDLE) begin
         if (cnt != 32'hffff_ffff) begin
            cnt_in = cnt + 32'd1;
         end
         if (!last) begin
            acc_in = acc_new;
            pos_in = pos + 3'd1;
         end else begin
            done   = 1'b1;
            acc_in = 32'd0;
            pos_in = 3'd0;
            unique case (ph)
               PH_COUNT: begin
                  hl_in = value;
                  if (value == 32'd0) begin
                     phase_in = PH_IDLE;
                     list_end = 1'b1;
                  end else begin
                     phase_in = PH_SIZE;
                  end
               end
               PH_SIZE: begin
                  if (value[31] || value == 32'd0) begin
                     cap_in = 1'b1;
                     pl_in  = 32'd0 - value;
                  end else begin
                     cap_in = 1'b0;
                     pl_in  = value;
                  end
                  phase_in = (value == 32'd0) ? PH_CATCHALL : PH_TYPE;
               end
               PH_TYPE: begin
                  phase_in = PH_ADDR;
               end
               PH_ADDR: begin
                  pl_in = pl_dec;
                  if (pl_dec != 32'd0) begin
                     phase_in = PH_TYPE;
                  end else if (cap) begin
                     phase_in = PH_CATCHALL;
                  end else begin
                     hl_in    = hl_dec;
                     list_end = (hl_dec == 32'd0);
                     phase_in = list_end ? PH_IDLE : PH_SIZE;
                  end
               end
               default: begin
                  cap_in   = 1'b0;
                  hl_in    = hl_dec;
                  list_end = (hl_dec == 32'd0);
                  phase_in = list_end ? PH_IDLE : PH_SIZE;
               end
            endcase
         end
      end

      rsp_word_in.value_done = done;
      rsp_word_in.value_kind = done ? ph : 3'd0;
      rsp_word_in.value_bits = done ? value : 32'd0;
      rsp_word_in.list_end   = list_end;
      rsp_word_in.bytes_used = cnt_in;

      rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_COUNT;
         acc_ff       <= 32'd0;
         pos_ff       <= 3'd0;
         hl_ff        <= 32'd0;
         pl_ff        <= 32'd0;
         cap_ff       <= 1'b0;
         cnt_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            phase_ff <= phase_in;
            acc_ff   <= acc_in;
            pos_ff   <= pos_in;
            hl_ff    <= hl_in;
            pl_ff    <= pl_in;
            cap_ff   <= cap_in;
            cnt_ff   <= cnt_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   `DCHLS_ASSERT_NOW(a_end_has_value, rsp_valid_ff && rsp_word_ff.list_end,
      rsp_word_ff.value_done, "list end reported without a completed value")
   `DCHLS_ASSERT_NOW(a_pos_range, 1'b1, pos_ff <= LAST_POS,
      "LEB128 byte position ran past the fifth byte")
   `DCHLS_ASSERT_NOW(a_idle_clean, phase_ff == PH_IDLE,
      (pos_ff == 3'd0) && (acc_ff == 32'd0), "idle walk holds a partial value")
   `DCHLS_ASSERT_NOW(a_no_value_zero, rsp_valid_ff && !rsp_word_ff.value_done,
      (rsp_word_ff.value_kind == 3'd0) && (rsp_word_ff.value_bits == 32'd0),
      "kind or value set without a completed value")
   `DCHLS_ASSERT_NEXT(a_pop_fills_slot, pop, rsp_valid_ff,
      "consumed byte produced no response")

endmodule

### src/dex_catch_handler_list_scanner_top.sv
// Top level of the catch handler list scanner.
// Depends on dchls_pkg, dchls_front and dchls_back.
`timescale 1ns / 1ps
// Scans a DEX encoded catch handler list one byte per word, one response word
// per request word, at a sustained rate of one word per clock while rsp_stall
// is low. A word with start_req set restarts the walk at the list count. Each
// response carries any LEB128 value the byte completes (kind: count, handler
// size, type index, address, catch-all address), the saturating byte count
// and an end-of-list flag; bytes after the end report no value and a frozen
// count. The queue takes an accepted word and the walker moves it into the
// response register when that register is free or being drained. The rate is
// set by the walker in the back end, which folds one byte into the
// accumulator and advances the walk combinationally as it pops the byte;
// a two-word queue in front and the response register behind let either side
// stall without stopping the other.

module dex_catch_handler_list_scanner_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  dchls_pkg::req_word_type  req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output dchls_pkg::rsp_word_type  rsp_word
);
   import dchls_pkg::*;

   // queue head toward the walker, and the walker's take
   q_head_type head;
   logic       pop;

   dchls_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .head      (head),
      .pop       (pop)
   );

   dchls_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

endmodule

### tb/dex_catch_handler_list_scanner_top_tb.sv
// Testbench for dex_catch_handler_list_scanner_top: directed and random catch handler lists,
// each response checked against an in-bench walk of the list.
// Depends on dchls_pkg and the scanner RTL.
`timescale 1ns / 1ps

module dex_catch_handler_list_scanner_top_tb;
   import dchls_pkg::*;

   // Clock, reset and ports; every input is known from time zero.
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   dex_catch_handler_list_scanner_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Walk state of the predictor; mirrors the scanner's own list walk.
   logic [2:0]  walk_phase;
   logic [31:0] acc;
   logic [2:0]  byte_pos;
   logic [31:0] hdl_left;
   logic [31:0] pair_left;
   logic        catch_all_due;
   logic [31:0] byte_total;

   // Responses predicted but not yet seen, oldest first.
   rsp_word_type scan_results_due[$];
   // Bytes of the list being assembled for sending.
   logic [7:0]   stream_bytes[$];

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int bytes_walked = 0;
   int values_decoded = 0;
   int lists_closed = 0;
   int rsp_checked = 0;
   int mismatches = 0;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic void clear_walk();
      walk_phase    = PH_COUNT;
      acc           = '0;
      byte_pos      = '0;
      hdl_left      = '0;
      pair_left     = '0;
      catch_all_due = 1'b0;
      byte_total    = '0;
   endfunction

   // Sign-extend the low nbits of v (nbits is 7, 14, 21 or 28).
   function automatic logic [31:0] sext_from(logic [31:0] v, int nbits);
      logic [31:0] sign;
      logic [31:0] mask;
      sign = 32'd1 << (nbits - 1);
      mask = (32'd1 << nbits) - 32'd1;
      return ((v & mask) ^ sign) - sign;
   endfunction

   // One handler finished; returns 1 when it was the last of the list.
   function automatic logic close_handler();
      hdl_left = hdl_left - 32'd1;
      if (hdl_left == 0) begin
         walk_phase = PH_IDLE;
         return 1'b1;
      end
      walk_phase = PH_SIZE;
      return 1'b0;
   endfunction

   // Fold one accepted byte into the walk and return the response it must cause.
   function automatic rsp_word_type scan_byte(req_word_type w);
      rsp_word_type r;
      logic [2:0]   pos;
      logic         last;
      logic [31:0]  v;
      r = '0;
      if (w.start_req)
         clear_walk();
      if (walk_phase < PH_IDLE) begin
         bytes_walked++;
         pos = byte_pos;
         if (byte_total != 32'hffff_ffff)
            byte_total = byte_total + 32'd1;
         // fifth byte always ends the value; only its low nibble fits in 32 bits
         if (pos >= LAST_POS) begin
            acc  = acc | {w.data_byte[3:0], 28'h0};
            last = 1'b1;
         end else begin
            acc  = acc | (32'(w.data_byte[6:0]) << (7 * pos));
            last = !w.data_byte[7];
         end
         if (!last) begin
            byte_pos = pos + 3'd1;
         end else begin
            v = acc;
            // short handler sizes extend from their own top payload bit
            if (walk_phase == PH_SIZE && pos < LAST_POS)
               v = sext_from(v, 7 * (int'(pos) + 1));
            r.value_done = 1'b1;
            r.value_kind = walk_phase;
            r.value_bits = v;
            values_decoded++;
            acc      = '0;
            byte_pos = '0;
            case (walk_phase)
               PH_COUNT: begin
                  hdl_left = v;
                  if (v == 0) begin
                     walk_phase = PH_IDLE;
                     r.list_end = 1'b1;
                  end else begin
                     walk_phase = PH_SIZE;
                  end
               end
               PH_SIZE: begin
                  // size <= 0 means a catch-all follows the |size| pairs
                  if (v[31] || v == 0) begin
                     catch_all_due = 1'b1;
                     pair_left     = 32'd0 - v;
                  end else begin
                     catch_all_due = 1'b0;
                     pair_left     = v;
                  end
                  walk_phase = (pair_left != 0) ? PH_TYPE : PH_CATCHALL;
               end
               PH_TYPE: begin
                  walk_phase = PH_ADDR;
               end
               PH_ADDR: begin
                  pair_left = pair_left - 32'd1;
                  if (pair_left != 0)
                     walk_phase = PH_TYPE;
                  else if (catch_all_due)
                     walk_phase = PH_CATCHALL;
                  else
                     r.list_end = close_handler();
               end
               default: begin
                  catch_all_due = 1'b0;
                  r.list_end    = close_handler();
               end
            endcase
            if (r.list_end)
               lists_closed++;
         end
      end
      r.bytes_used = byte_total;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Monitors: predict on every accepted request word, check every
   // accepted response word against the oldest prediction.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         scan_results_due.push_back(scan_byte(req_word));
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_checked++;
         if (scan_results_due.size() == 0) begin
            mismatches++;
            $display("%0t: response word with none expected, got done=%0b kind=%0d",
                     $time, rsp_word.value_done, rsp_word.value_kind,
                     " bits=%h end=%0b used=%0d",
                     rsp_word.value_bits, rsp_word.list_end, rsp_word.bytes_used);
         end else begin
            want = scan_results_due.pop_front();
            if (rsp_word.value_done !== want.value_done ||
                rsp_word.value_kind !== want.value_kind ||
                rsp_word.value_bits !== want.value_bits ||
                rsp_word.list_end   !== want.list_end   ||
                rsp_word.bytes_used !== want.bytes_used) begin
               mismatches++;
               $display("%0t: response mismatch: expected done=%0b kind=%0d bits=%h",
                        $time, want.value_done, want.value_kind, want.value_bits,
                        " end=%0b used=%0d", want.list_end, want.bytes_used,
                        "; got done=%0b kind=%0d bits=%h",
                        rsp_word.value_done, rsp_word.value_kind, rsp_word.value_bits,
                        " end=%0b used=%0d", rsp_word.list_end, rsp_word.bytes_used);
            end
         end
      end
   end

   // Receiver backpressure, redrawn every cycle.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
   end

   // ------------------------------------------------------------------
   // Sending
   // ------------------------------------------------------------------
   // Called at a falling edge; returns at the falling edge after acceptance.
   // Valid stays high between back-to-back words.
   task automatic send_byte(input logic [7:0] b, input logic st);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_word  <= '{data_byte: b, start_req: st};
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Send the assembled bytes; start_req only on the first if asked.
   task automatic send_stream(input logic with_start);
      foreach (stream_bytes[i])
         send_byte(stream_bytes[i], with_start && i == 0);
      stream_bytes.delete();
   endtask

   // ------------------------------------------------------------------
   // List building
   // ------------------------------------------------------------------
   // LEB128 encode v, at least len bytes long (non-minimal padding when len
   // exceeds the natural length). A fifth byte gets random unchecked upper bits.
   function automatic void push_leb(logic [31:0] v, logic sgn, int len);
      logic [63:0] ext;
      int          n;
      ext = sgn ? {{32{v[31]}}, v} : {32'h0, v};
      n = 1;
      while (n < 5 && (sgn ? (sext_from(v, 7 * n) != v) : ((v >> (7 * n)) != 0)))
         n++;
      if (len > n)
         n = len;
      for (int i = 0; i < n; i++) begin
         if (i == 4)
            stream_bytes.push_back({4'($urandom), v[31:28]});
         else
            stream_bytes.push_back({i != n - 1, ext[7 * i +: 7]});
      end
   endfunction

   // Mostly minimal encodings, sometimes padded out as far as five bytes.
   function automatic int pick_len();
      return ($urandom_range(3) == 0) ? int'($urandom_range(1, 5)) : 0;
   endfunction

   function automatic logic [31:0] rand_val();
      case ($urandom_range(5))
         0: return $urandom_range(127);
         1: return $urandom_range(16383);
         2: return $urandom_range(2097151);
         3: return $urandom;
         4: begin
            case ($urandom_range(3))
               0: return 32'h0000_0000;
               1: return 32'hffff_ffff;
               2: return 32'h7fff_ffff;
               default: return 32'h8000_0000;
            endcase
         end
         default: return $urandom_range(268435455);
      endcase
   endfunction

   // A list with 0..3 handlers of up to 3 pairs. Now and then the count or a
   // size is an arbitrary value, which leaves the walk open for a later start.
   function automatic void build_list();
      int          n_hdl;
      int          n_pairs;
      int          s;
      logic [31:0] size_v;
      logic [31:0] mag;
      n_hdl = $urandom_range(3);
      push_leb(($urandom_range(9) == 0) ? rand_val() : 32'(n_hdl), 1'b0, pick_len());
      for (int h = 0; h < n_hdl; h++) begin
         s = int'($urandom_range(6)) - 3;
         size_v = ($urandom_range(9) == 0) ? rand_val() : 32'(s);
         push_leb(size_v, 1'b1, pick_len());
         mag = size_v[31] ? 32'd0 - size_v : size_v;
         n_pairs = (mag > 3) ? 3 : int'(mag);
         for (int p = 0; p < n_pairs; p++) begin
            push_leb(rand_val(), 1'b0, pick_len());
            push_leb(rand_val(), 1'b0, pick_len());
         end
         if ((size_v[31] || size_v == 0) && mag <= 3)
            push_leb(rand_val(), 1'b0, pick_len());
      end
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Right after reset the scanner already expects a count: a lone zero is an
   // empty list, and a byte after it is dropped with the count frozen.
   task automatic test_bytes_before_start();
      stream_bytes = '{8'h00, 8'hff};
      send_stream(1'b0);
   endtask

   // Empty list with a padded zero count, then a stray byte past the end.
   task automatic test_empty_list();
      stream_bytes = '{8'h80, 8'h00};
      send_stream(1'b1);
      stream_bytes = '{8'h81};
      send_stream(1'b0);
   endtask

   // One handler of size zero: catch-all only, given as five all-ones bytes so
   // the fifth byte's unchecked upper bits are set.
   task automatic test_catch_all_only();
      stream_bytes = '{8'h01, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff};
      send_stream(1'b1);
   endtask

   // Two handlers: size -1 with a pair and a catch-all, then size +1 padded to
   // four bytes with a plain pair.
   task automatic test_pairs_and_catch_all();
      stream_bytes = '{8'h02, 8'h7f, 8'h80, 8'h00, 8'h01, 8'h05,
                       8'h81, 8'h80, 8'h80, 8'h00, 8'h7f, 8'h00};
      send_stream(1'b1);
   endtask

   // Size 0x80000000 in five bytes: no sign extension, 2^31 pairs to go.
   // The walk is left open; the next start cuts it off.
   task automatic test_most_negative_size();
      stream_bytes = '{8'h01, 8'h80, 8'h80, 8'h80, 8'h80, 8'h08, 8'h01};
      send_stream(1'b1);
   endtask

   // Mostly well-formed lists with random content; the rest cut-off lists,
   // noise with random start bits, and bytes trailing a list.
   task automatic test_random_lists(input int idle_pct, input int stall_pct, input int quota);
      int goal;
      int pick;
      int cut;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      goal = bytes_walked + quota;
      while (bytes_walked < goal) begin
         pick = $urandom_range(99);
         if (pick < 70) begin
            build_list();
            send_stream(1'b1);
         end else if (pick < 80) begin
            build_list();
            cut = $urandom_range(1, stream_bytes.size());
            while (stream_bytes.size() > cut)
               void'(stream_bytes.pop_back());
            send_stream(1'b1);
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 6))
               send_byte(8'($urandom), $urandom_range(3) == 0);
         end else begin
            repeat ($urandom_range(1, 4))
               send_byte(8'($urandom), 1'b0);
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      clear_walk();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_bytes_before_start();
      test_empty_list();
      test_catch_all_only();
      test_pairs_and_catch_all();
      test_most_negative_size();

      test_random_lists(0, 0, 125);     // full rate both ways
      test_random_lists(65, 0, 125);    // sparse sender
      test_random_lists(0, 65, 125);    // heavy backpressure
      test_random_lists(18, 18, 125);   // light gaps on both sides

      req_valid <= 1'b0;
      while (scan_results_due.size() != 0)
         @(posedge clock);
      // then idle on to catch any extra response word
      repeat (20) @(posedge clock);

      $display("Covered %0d walked bytes, %0d decoded values and %0d closed lists;",
               bytes_walked, values_decoded, lists_closed);
      $display("%0d response words checked, %0d mismatched.", rsp_checked, mismatches);
      if (mismatches == 0 && scan_results_due.size() == 0) begin
         $display("PASS dex_catch_handler_list_scanner_top");
      end else begin
         $display("FAIL dex_catch_handler_list_scanner_top");
      end
      $finish;
   end

   // Hang guard: far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("Timed out with %0d responses outstanding.", scan_results_due.size());
      $display("FAIL dex_catch_handler_list_scanner_top");
      $finish;
   end

endmodule
